/* src/u2a_pkg.sv */
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types, constants and helpers for the unsigned-to-ASCII digit
// converter: payload structs, sequencer states, digit glyph table.
// ----------------------------------------------------------------------------
package u2a_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int IN_VALUE_W     = 32;
   localparam int CHAR_W         = 7;
   localparam int DIGIT_W        = 4;
   // double-dabble bits consumed per cycle by the shared unit
   localparam int BITS_PER_STEP  = 2;

   localparam logic OP_DEC = 1'b0;
   localparam logic OP_HEX = 1'b1;

   localparam logic [CHAR_W-1:0] GLYPH_TABLE [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
   };

   typedef struct packed {
      logic                  operation;
      logic [IN_VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last_digit;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic step;
      logic hex;
   } unit_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_FIND,
      ST_EMIT
   } state_type;

   // decimal digits of 2**vb - 1 (1233/4096 ~ log10(2)); covers hex too
   function automatic int max_digits(input int vb);
      return ((vb * 1233) >> 12) + 1;
   endfunction

   function automatic int shift_width(input int vb);
      return ((vb + BITS_PER_STEP - 1) / BITS_PER_STEP) * BITS_PER_STEP;
   endfunction

   function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
      return GLYPH_TABLE[d];
   endfunction

endpackage

/* src/u2a_bcd_unit.sv */
// ----------------------------------------------------------------------------
// u2a_bcd_unit
// Shared shift/add-3 unit: loads the value, then converts binary to BCD a
// few bits per step. In hex mode the nibbles are loaded as digits directly.
// ----------------------------------------------------------------------------
module u2a_bcd_unit #(
   parameter int VALUE_BITS = u2a_pkg::VALUE_BITS_DEF
) (
   input  logic                                  clock,
   input  u2a_pkg::unit_cmd_type                 cmd,
   input  logic [u2a_pkg::IN_VALUE_W-1:0]        req_value,
   output logic [u2a_pkg::max_digits(VALUE_BITS)*u2a_pkg::DIGIT_W-1:0] digits
);
   import u2a_pkg::*;

   localparam int MAX_DIGITS = max_digits(VALUE_BITS);
   localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
   localparam int SHIFT_W    = shift_width(VALUE_BITS);

   logic [VALUE_BITS-1:0] masked;
   logic [SHIFT_W-1:0]    bin_ff, bin_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;

   generate
      if (VALUE_BITS <= IN_VALUE_W) begin : g_trunc
         assign masked = req_value[VALUE_BITS-1:0];
      end else begin : g_ext
         assign masked = {{(VALUE_BITS-IN_VALUE_W){1'b0}}, req_value};
      end
   endgenerate

   always_comb begin
      logic [SHIFT_W-1:0] b;
      logic [BCD_W-1:0]   d;
      b = bin_ff;
      d = bcd_ff;
      if (cmd.load) begin
         b = SHIFT_W'(masked);
         d = (cmd.hex == OP_HEX) ? BCD_W'(masked) : '0;
      end else if (cmd.step) begin
         for (int j = 0; j < BITS_PER_STEP; j++) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
               if (d[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
                  d[i*DIGIT_W +: DIGIT_W] = d[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end
            d = {d[BCD_W-2:0], b[SHIFT_W-1]};
            b = {b[SHIFT_W-2:0], 1'b0};
         end
      end
      bin_in = b;
      bcd_in = d;
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign digits = bcd_ff;

endmodule

/* src/u2a_ctrl.sv */
// ----------------------------------------------------------------------------
// u2a_ctrl
// Sequencer: runs the conversion steps (decimal only), finds the leading digit, then emits
// one character per cycle, most significant first.
// ----------------------------------------------------------------------------
module u2a_ctrl #(
   parameter int VALUE_BITS = u2a_pkg::VALUE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  req_op,
   output logic                                  busy,
   input  logic [u2a_pkg::max_digits(VALUE_BITS)*u2a_pkg::DIGIT_W-1:0] digits,
   output u2a_pkg::unit_cmd_type                 cmd,
   output logic                                  rsp_strobe,
   output u2a_pkg::rsp_type                      rsp_data
);
   import u2a_pkg::*;

   localparam int MAX_DIGITS = max_digits(VALUE_BITS);
   localparam int STEPS      = shift_width(VALUE_BITS) / BITS_PER_STEP;
   localparam int CNT_W      = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int IDX_W      = $clog2(MAX_DIGITS);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] msd;
   logic [DIGIT_W-1:0] cur_digit;

   // highest nonzero digit; zero value leaves index 0
   always_comb begin
      msd = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (digits[i*DIGIT_W +: DIGIT_W] != '0)
            msd = IDX_W'(i);
      end
   end

   assign cur_digit = digits[idx_ff*DIGIT_W +: DIGIT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in            = state_ff;
      cnt_in              = cnt_ff;
      idx_in              = idx_ff;
      busy                = 1'b1;
      cmd                 = '0;
      cmd.hex             = req_op;
      rsp_strobe          = 1'b0;
      rsp_data.digit_char = glyph(cur_digit);
      rsp_data.last_digit = (idx_ff == '0);
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = (req_op == OP_HEX) ? ST_FIND : ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(STEPS - 1))
               state_in = ST_FIND;
         end
         ST_FIND: begin
            idx_in   = msd;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_strobe = 1'b1;
            if (idx_ff == '0)
               state_in = ST_IDLE;
            else
               idx_in = idx_ff - IDX_W'(1);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not make block busy");

   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_digit |=> rsp_strobe)
      else $error("gap inside a digit run");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_digit |=> !rsp_strobe && !busy)
      else $error("run continued past last digit");

endmodule

/* src/unsigned_to_ascii_digits_top.sv */
// Decimal items pass load, the double-dabble steps and the leading-digit search
//   before the first character; hex items skip the steps. Then one character per
//   cycle, with no gaps. A new item is taken only after the last character (busy);
//   the shared double-dabble unit takes 2 bits per cycle while converting.
// Results carry a one-cycle strobe and cannot be stalled by the receiver.
// Synchronous active-high reset returns the sequencer to idle; no other state.
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits_top
// Converts an unsigned value to ASCII decimal or upper-case hex characters,
// most significant first, no leading zeros.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_digits_top #(
   parameter int VALUE_BITS = u2a_pkg::VALUE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  u2a_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output u2a_pkg::rsp_type  rsp_data
);
   import u2a_pkg::*;

   localparam int BCD_W = max_digits(VALUE_BITS) * DIGIT_W;

   unit_cmd_type     cmd;
   logic [BCD_W-1:0] digits;

   u2a_ctrl #(
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_op     (req_data.operation),
      .busy       (busy),
      .digits     (digits),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   u2a_bcd_unit #(
      .VALUE_BITS (VALUE_BITS)
   ) u_unit (
      .clock     (clock),
      .cmd       (cmd),
      .req_value (req_data.value),
      .digits    (digits)
   );

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench for unsigned_to_ascii_digits_top
// Sends decimal and hex conversion commands with random pacing. The expected
// digit characters are worked out locally for every accepted item. Each
// strobed character is checked in order against them.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import u2a_pkg::*;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] ASCII_UPPER = 7'h41;
   localparam int QUIET_LIMIT   = 2000;
   localparam int TAIL_CYCLES   = 50;
   localparam int RANDOM_ITEMS  = 290;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      req_type cmd;
      int      gap;    // idle cycles before this item goes on the port
      bit      drain;  // hold off until all pending characters are out
   } send_slot_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   send_slot_type send_queue[$];
   rsp_type       chars_due[$];
   bit            holding = 1'b0;
   int            gap_left = 0;
   int            mismatches = 0;
   int            quiet_cycles = 0;
   int            burst_left = 0;

   unsigned_to_ascii_digits_top DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Digits are produced least significant first, then flipped.
   function automatic void queue_digit_chars(input req_type item);
      logic [IN_VALUE_W-1:0] rest;
      logic [DIGIT_W-1:0]    d;
      rsp_type               ch;
      rsp_type               run[$];
      rest = item.value;
      do begin
         if (item.operation == OP_HEX) begin
            d = rest[DIGIT_W-1:0];
            rest = rest >> 4;
         end else begin
            d = DIGIT_W'(rest % 10);
            rest = rest / 10;
         end
         ch.digit_char = (d < 10) ? ASCII_ZERO + CHAR_W'(d) : ASCII_UPPER + CHAR_W'(d - 4'd10);
         ch.last_digit = (run.size() == 0);
         run.push_front(ch);
      end while (rest != 0);
      foreach (run[i]) chars_due.push_back(run[i]);
   endfunction

   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         burst_left = $urandom_range(10, 30);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   function automatic logic [IN_VALUE_W-1:0] random_value();
      int          w;
      int          k;
      logic [63:0] v;
      case ($urandom_range(0, 9))
         0: begin
            // just at or just under a power of ten
            v = 64'd1;
            k = $urandom_range(0, 9);
            repeat (k) v = v * 10;
            if ($urandom_range(0, 1)) v = v - 1;
         end
         1: v = {32'b0, $urandom()};
         default: begin
            w = $urandom_range(0, IN_VALUE_W);
            if (w == 0) begin
               v = '0;
            end else begin
               v = {32'b0, $urandom()} & ((64'd1 << w) - 64'd1);
               v[w-1] = 1'b1;
            end
         end
      endcase
      return v[IN_VALUE_W-1:0];
   endfunction

   task automatic add_item(input logic op, input logic [IN_VALUE_W-1:0] value,
                           input bit drain);
      send_slot_type s;
      s.cmd.operation = op;
      s.cmd.value     = value;
      s.gap           = pick_gap();
      s.drain         = drain;
      send_queue.push_back(s);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
         holding  = 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            queue_digit_chars(req_data);
            holding = 1'b0;
            if (send_queue.size() > 0) gap_left = send_queue[0].gap;
         end
         if (!holding) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (send_queue.size() > 0 &&
                         !(send_queue[0].drain && chars_due.size() > 0)) begin
               req_data <= send_queue[0].cmd;
               void'(send_queue.pop_front());
               holding = 1'b1;
            end
         end
         start <= holding;
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (chars_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected character: got char %h last %b",
                        rsp_data.digit_char, rsp_data.last_digit);
         end else begin
            want = chars_due.pop_front();
            if (rsp_data.digit_char !== want.digit_char ||
                rsp_data.last_digit !== want.last_digit) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("character mismatch: expected char %h last %b, got char %h last %b",
                           want.digit_char, want.last_digit,
                           rsp_data.digit_char, rsp_data.last_digit);
            end
         end
      end
   end

   // watchdog: cycles with neither an item nor a character accepted
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // directed: zero, extremes, digit-count boundaries, every hex letter
      add_item(OP_DEC, 32'd0, 1'b0);
      add_item(OP_HEX, 32'd0, 1'b0);
      add_item(OP_DEC, 32'hFFFF_FFFF, 1'b0);
      add_item(OP_HEX, 32'hFFFF_FFFF, 1'b0);
      add_item(OP_DEC, 32'd1, 1'b0);
      add_item(OP_DEC, 32'd9, 1'b0);
      add_item(OP_DEC, 32'd10, 1'b0);
      add_item(OP_DEC, 32'd99, 1'b0);
      add_item(OP_DEC, 32'd100, 1'b0);
      add_item(OP_DEC, 32'd999_999_999, 1'b0);
      add_item(OP_DEC, 32'd1_000_000_000, 1'b1);
      add_item(OP_DEC, 32'h8000_0000, 1'b0);
      add_item(OP_DEC, 32'h5555_5555, 1'b0);
      add_item(OP_DEC, 32'hAAAA_AAAA, 1'b0);
      add_item(OP_HEX, 32'h0000_000F, 1'b0);
      add_item(OP_HEX, 32'h0000_0010, 1'b0);
      add_item(OP_HEX, 32'hABCD_EF01, 1'b0);
      add_item(OP_HEX, 32'h8000_0000, 1'b0);
      add_item(OP_HEX, 32'h1234_5678, 1'b0);
      add_item(OP_HEX, 32'hFEDC_BA98, 1'b0);
      add_item(OP_HEX, 32'h0000_FFFF, 1'b0);
      add_item(OP_HEX, 32'd1, 1'b0);
      repeat (RANDOM_ITEMS)
         add_item(logic'($urandom_range(0, 1)), random_value(), $urandom_range(0, 39) == 0);

      reset <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (send_queue.size() > 0 || holding || chars_due.size() > 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && chars_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
